// ----- rtl/core/load_cell_tare_scale_average_macros.svh -----
// Assertion macros shared by the load-cell tare and averaging RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef LOAD_CELL_TARE_SCALE_AVERAGE_MACROS_SVH
`define LOAD_CELL_TARE_SCALE_AVERAGE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LCTSA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LCTSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/lctsa_pkg.sv -----
// Shared types and constants for the load-cell tare and averaging block.
// No dependencies; used by lctsa_div, lctsa_window and the top level.
`default_nettype none

package lctsa_pkg;

  // Field widths.
  localparam int RAW_W       = 24;
  localparam int WGT_W       = 27;
  localparam int SCALE_W     = 16;
  localparam int DVS_W       = SCALE_W + 1;
  localparam int OUT_TDATA_W = 32;

  // Calibration factor after reset.
  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd815;

  // Input item kinds carried on in_tuser.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TARE   = 1'b1;

  // Commands from the sequencer to the averaging window.
  typedef struct packed {
    logic restart;
    logic add;
  } win_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/lctsa_div.sv -----
// Shared iterative unsigned divider: one quotient bit per cycle (restoring).
// Depends on lctsa_pkg for the divisor width.
`default_nettype none

module lctsa_div #(
  parameter int DVD_W = 30
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [DVD_W-1:0]            dividend,
  input  wire logic [lctsa_pkg::DVS_W-1:0] divisor,
  output logic                             done,
  output logic [DVD_W-1:0]                 quotient
);

  localparam int DVS_W = lctsa_pkg::DVS_W;
  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;

  logic [DVS_W:0]   rem_sh;
  logic [DVS_W+1:0] diff;
  logic             borrow;
  logic [DVS_W-1:0] rem_nxt;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    rem_sh  = {rem_r, quo_r[DVD_W-1]};
    diff    = {1'b0, rem_sh} - {2'b00, dvs_r};
    borrow  = diff[DVS_W+1];
    rem_nxt = borrow ? rem_sh[DVS_W-1:0] : diff[DVS_W-1:0];
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: the quotient register doubles as the dividend shifter.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DVD_W-2:0], ~borrow};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ----- rtl/core/lctsa_window.sv -----
// Ring window of recent weights with running sum, fill count and write slot.
// Depends on lctsa_pkg for the weight width and the control struct.
`default_nettype none
`include "load_cell_tare_scale_average_macros.svh"

module lctsa_window #(
  parameter int WINDOW = 5
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire lctsa_pkg::win_ctl_t                   ctl,
  input  wire logic signed [lctsa_pkg::WGT_W-1:0]    wgt_in,
  output logic signed [lctsa_pkg::WGT_W+$clog2(WINDOW+1)-1:0] sum_o,
  output logic [$clog2(WINDOW+1)-1:0]                cnt_o
);

  localparam int WGT_W  = lctsa_pkg::WGT_W;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = WGT_W + CNT_W;
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  logic signed [WGT_W-1:0] store_r [WINDOW];
  logic signed [SUM_W-1:0] sum_r;
  logic signed [SUM_W-1:0] sum_nxt;
  logic [CNT_W-1:0]        cnt_r;
  logic [SLOT_W-1:0]       slot_r;
  logic                    full;
  logic signed [SUM_W-1:0] old_w;

  // The oldest entry leaves the sum only once the window is full.
  always_comb begin
    full    = (cnt_r == CNT_W'(WINDOW));
    old_w   = full ? SUM_W'(store_r[slot_r]) : '0;
    sum_nxt = sum_r + SUM_W'(wgt_in) - old_w;
  end

  // Sum, fill count and slot pointer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      cnt_r  <= '0;
      slot_r <= '0;
    end else if (ctl.restart) begin
      sum_r  <= '0;
      cnt_r  <= '0;
      slot_r <= '0;
    end else if (ctl.add) begin
      sum_r <= sum_nxt;
      if (!full) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (slot_r == SLOT_W'(WINDOW - 1)) begin
        slot_r <= '0;
      end else begin
        slot_r <= slot_r + SLOT_W'(1);
      end
    end
  end

  // Weight storage, written at the current slot.
  always_ff @(posedge clk) begin
    if (ctl.add && !ctl.restart) begin
      store_r[slot_r] <= wgt_in;
    end
  end

  assign sum_o = sum_r;
  assign cnt_o = cnt_r;

  `LCTSA_ASSERT_IMPL(a_slot_tracks_fill, clk, rst_n, (cnt_r != CNT_W'(WINDOW)), (CNT_W'(slot_r) == cnt_r), "write slot differs from fill count while filling")
  `LCTSA_ASSERT_NEXT(a_full_stays_full, clk, rst_n, (ctl.add && !ctl.restart && full), (cnt_r == CNT_W'(WINDOW)), "fill count left full state on add")
  `LCTSA_ASSERT_NEXT(a_restart_clears, clk, rst_n, ctl.restart, ((cnt_r == '0) && (sum_r == '0)), "restart did not clear sum and count")

endmodule

`default_nettype wire

// ----- rtl/core/load_cell_tare_scale_average.sv -----
// Load-cell tare, calibration and moving-average block (top level).
// Uses the shared divider lctsa_div, the ring window lctsa_window and lctsa_pkg.
//
// Usage:
//   Input requests arrive on in_tvalid/in_tready/in_tdata/in_tuser. in_tuser
//   is the command (0 = raw sample, 1 = tare request), in_tdata the signed
//   24-bit raw reading. Each request yields exactly one result on out_*:
//   out_tdata holds the signed 27-bit averaged weight in grams, out_tuser is
//   high when no tare is pending.
//   A tare request or the first sample after it (which becomes the offset) goes
//   straight from S_IDLE to S_OUT. A normal sample passes S_PREP, S_DIV1, S_AVG,
//   S_DIV2 and S_OUT: one divider, iterating one bit per cycle, is used for the
//   gram conversion and then for the window average. in_tready is high only while
//   the sequencer is idle, so one request is processed at a time.
//   The result sits in an output register; a new request is accepted while it
//   waits, and a later result waits in the sequencer until that register is taken.
//   scale_x2 is written through cfg_valid/cfg_data (cfg_ready is always high);
//   the user must write it only while the block is idle; the block does not
//   enforce this. Synchronous reset sets scale_x2 to 815, clears offset and
//   average, empties the window and marks a tare as pending.
`default_nettype none
`include "load_cell_tare_scale_average_macros.svh"

module load_cell_tare_scale_average #(
  parameter int WINDOW = 5
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Input request channel.
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [lctsa_pkg::RAW_W-1:0]         in_tdata,   // [23:0] raw_sample
  input  wire logic                                in_tuser,   // [0] cmd
  // Result channel.
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [lctsa_pkg::OUT_TDATA_W-1:0]        out_tdata,  // [26:0] weight_grams
  output logic                                     out_tuser,  // [0] tare_done
  // Configuration write channel.
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [lctsa_pkg::SCALE_W-1:0]       cfg_data    // scale_x2
);

  localparam int RAW_W   = lctsa_pkg::RAW_W;
  localparam int WGT_W   = lctsa_pkg::WGT_W;
  localparam int SCALE_W = lctsa_pkg::SCALE_W;
  localparam int DVS_W   = lctsa_pkg::DVS_W;
  localparam int CNT_W   = $clog2(WINDOW + 1);
  localparam int SUM_W   = WGT_W + CNT_W;
  localparam int DVD_W   = SUM_W;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PREP = 6'b000010,
    S_DIV1 = 6'b000100,
    S_AVG  = 6'b001000,
    S_DIV2 = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t                    state_r;
  state_t                    state_nxt;
  logic [SCALE_W-1:0]        scale_r;
  logic signed [RAW_W-1:0]   raw_r;
  logic signed [RAW_W-1:0]   offset_r;
  logic                      pending_r;
  logic signed [WGT_W-1:0]   avg_r;
  logic                      neg_r;
  logic                      out_valid_r;
  logic [WGT_W-1:0]          out_data_r;
  logic                      out_user_r;

  logic                      in_acc;
  logic                      out_load;
  logic signed [RAW_W:0]     delta;
  logic [RAW_W:0]            delta_mag;
  logic [SCALE_W-1:0]        scale_eff;
  logic signed [SUM_W-1:0]   win_sum;
  logic [CNT_W-1:0]          win_cnt;
  logic [SUM_W-1:0]          sum_mag;
  logic                      div_start;
  logic [DVD_W-1:0]          div_dvd;
  logic [DVS_W-1:0]          div_dvs;
  logic                      div_done;
  logic [DVD_W-1:0]          div_quo;
  logic [WGT_W-1:0]          quo_w;
  logic signed [WGT_W-1:0]   quo_signed;
  lctsa_pkg::win_ctl_t       win_ctl;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_tready);

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= lctsa_pkg::SCALE_RESET;
    end else if (cfg_valid) begin
      scale_r <= cfg_data;
    end
  end

  // Operand preparation for the divider.
  always_comb begin
    scale_eff  = (scale_r == '0) ? SCALE_W'(1) : scale_r;
    delta      = $signed({raw_r[RAW_W-1], raw_r}) - $signed({offset_r[RAW_W-1], offset_r});
    delta_mag  = delta[RAW_W] ? (RAW_W+1)'(-delta) : delta;
    sum_mag    = win_sum[SUM_W-1] ? SUM_W'(-win_sum) : win_sum;
    div_start  = (state_r == S_PREP) || (state_r == S_AVG);
    if (state_r == S_PREP) begin
      div_dvd = DVD_W'({delta_mag, 2'b00}) + DVD_W'(scale_eff);
      div_dvs = {scale_eff, 1'b0};
    end else begin
      div_dvd = DVD_W'(sum_mag);
      div_dvs = DVS_W'(win_cnt);
    end
    quo_w      = div_quo[WGT_W-1:0];
    quo_signed = neg_r ? -$signed(quo_w) : $signed(quo_w);
  end

  // Window commands.
  always_comb begin
    win_ctl.restart = in_acc && (in_tuser == lctsa_pkg::CMD_SAMPLE) && pending_r;
    win_ctl.add     = (state_r == S_DIV1) && div_done;
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser == lctsa_pkg::CMD_TARE || pending_r) begin
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_PREP;
          end
        end
      end
      S_PREP: state_nxt = S_DIV1;
      S_DIV1: begin
        if (div_done) begin
          state_nxt = S_AVG;
        end
      end
      S_AVG:  state_nxt = S_DIV2;
      S_DIV2: begin
        if (div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state: sequencer, tare handling, average and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pending_r   <= 1'b1;
      offset_r    <= '0;
      avg_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        if (in_tuser == lctsa_pkg::CMD_TARE) begin
          pending_r <= 1'b1;
        end else if (pending_r) begin
          offset_r  <= $signed(in_tdata);
          avg_r     <= '0;
          pending_r <= 1'b0;
        end
      end
      if ((state_r == S_DIV2) && div_done) begin
        avg_r <= quo_signed;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      raw_r <= $signed(in_tdata);
    end
    if (state_r == S_PREP) begin
      neg_r <= delta[RAW_W];
    end else if (state_r == S_AVG) begin
      neg_r <= win_sum[SUM_W-1];
    end
    if (out_load) begin
      out_data_r <= avg_r;
      out_user_r <= !pending_r;
    end
  end

  lctsa_div #(
    .DVD_W (DVD_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo)
  );

  lctsa_window #(
    .WINDOW (WINDOW)
  ) u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (win_ctl),
    .wgt_in (quo_signed),
    .sum_o  (win_sum),
    .cnt_o  (win_cnt)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = lctsa_pkg::OUT_TDATA_W'(out_data_r);
  assign out_tuser  = out_user_r;

  `LCTSA_ASSERT_IMPL(a_done_in_div, clk, rst_n, div_done, ((state_r == S_DIV1) || (state_r == S_DIV2)), "divider finished outside a divide state")
  `LCTSA_ASSERT_NEXT(a_tare_sets_pending, clk, rst_n, (in_acc && (in_tuser == lctsa_pkg::CMD_TARE)), (pending_r && (state_r == S_OUT)), "tare request did not set pending")
  `LCTSA_ASSERT_NEXT(a_result_waits, clk, rst_n, ((state_r == S_OUT) && out_valid_r && !out_tready), (state_r == S_OUT), "result left sequencer while output was busy")

endmodule

`default_nettype wire

// ----- tb/sv/tare_average_checker.sv -----
`timescale 1ns / 100ps
// Result checker for the load-cell tare and averaging block: watches the request,
// configuration and result channels, predicts every weight and compares it.
// Depends on lctsa_pkg for field widths and command codes.
module tare_average_checker #(
  parameter int WINDOW_LEN = 5
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [lctsa_pkg::RAW_W-1:0]       in_tdata,
  input  logic                              in_tuser,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [lctsa_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                              out_tuser,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [lctsa_pkg::SCALE_W-1:0]     cfg_data,
  output int                                mismatch_count,
  output int                                open_count,
  output int                                result_count
);

  localparam int RAW_W       = lctsa_pkg::RAW_W;
  localparam int WGT_W       = lctsa_pkg::WGT_W;
  localparam int SCALE_W     = lctsa_pkg::SCALE_W;
  localparam int OUT_TDATA_W = lctsa_pkg::OUT_TDATA_W;

  typedef struct packed {
    logic [WGT_W-1:0] weight;
    logic             tare_done;
  } weight_result_t;

  // Expected results, oldest first.
  weight_result_t expected_weights[$];

  // Shadow copy of the calibration and averaging state.
  logic [SCALE_W-1:0]      scale_x2;
  logic signed [RAW_W-1:0] tare_offset;
  logic                    tare_pending;
  longint                  window_store[WINDOW_LEN];
  longint                  window_sum;
  int                      fill_count;
  int                      write_slot;
  longint                  average_weight;
  int                      errors = 0;
  int                      checked = 0;

  // Grams from a raw delta: 2*delta/scale rounded half away from zero.
  // A zero scale acts as one.
  function automatic longint to_grams(input longint delta);
    longint divisor;
    longint mag;
    divisor = (scale_x2 == '0) ? 64'sd1 : longint'(scale_x2);
    mag = (delta < 0) ? -delta : delta;
    mag = (4 * mag + divisor) / (2 * divisor);
    return (delta < 0) ? -mag : mag;
  endfunction

  // Applies one request to the shadow state and returns the result it causes.
  function automatic weight_result_t predict_weight(input logic cmd,
                                                    input logic signed [RAW_W-1:0] raw);
    weight_result_t res;
    longint grams;
    if (cmd == lctsa_pkg::CMD_TARE) begin
      tare_pending = 1'b1;
    end else if (tare_pending) begin
      // This sample becomes the new zero point and the average restarts.
      tare_offset    = raw;
      average_weight = 0;
      window_sum     = 0;
      fill_count     = 0;
      write_slot     = 0;
      tare_pending   = 1'b0;
    end else begin
      grams = to_grams(longint'(raw) - longint'(tare_offset));
      if (fill_count < WINDOW_LEN) begin
        fill_count++;
      end else begin
        window_sum -= window_store[write_slot];
      end
      window_store[write_slot] = grams;
      window_sum += grams;
      write_slot = (write_slot + 1) % WINDOW_LEN;
      // Signed division truncates toward zero.
      average_weight = window_sum / fill_count;
    end
    res.weight    = average_weight[WGT_W-1:0];
    res.tare_done = !tare_pending;
    return res;
  endfunction

  // Track the channels at each rising edge; results are checked before new
  // expectations are queued so a stray result never meets a fresh entry.
  always @(posedge clk) begin
    weight_result_t want;
    if (!rst_n) begin
      scale_x2       = lctsa_pkg::SCALE_RESET;
      tare_offset    = '0;
      tare_pending   = 1'b1;
      window_sum     = 0;
      fill_count     = 0;
      write_slot     = 0;
      average_weight = 0;
      expected_weights.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        checked++;
        if (expected_weights.size() == 0) begin
          errors++;
          $display("%0t: result with none expected, actual weight %0d tare_done %0b",
                   $time, $signed(out_tdata[WGT_W-1:0]), out_tuser);
        end else begin
          want = expected_weights.pop_front();
          if (out_tdata !== OUT_TDATA_W'(want.weight)) begin
            errors++;
            $display("%0t: weight mismatch, expected %0d (0x%h), actual %0d (0x%h)",
                     $time, $signed(want.weight), OUT_TDATA_W'(want.weight),
                     $signed(out_tdata[WGT_W-1:0]), out_tdata);
          end
          if (out_tuser !== want.tare_done) begin
            errors++;
            $display("%0t: tare_done mismatch, expected %0b, actual %0b",
                     $time, want.tare_done, out_tuser);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        scale_x2 = cfg_data;
      end
      if (in_tvalid && in_tready) begin
        expected_weights.push_back(predict_weight(in_tuser, in_tdata));
      end
    end
    mismatch_count <= errors;
    open_count     <= expected_weights.size();
    result_count   <= checked;
  end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// Top of the load-cell tare and averaging testbench: clock, reset, request
// stimulus, calibration writes and the verdict. Uses lctsa_pkg and tare_average_checker.
module testbench;

  localparam int RAW_W         = lctsa_pkg::RAW_W;
  localparam int SCALE_W       = lctsa_pkg::SCALE_W;
  localparam int OUT_TDATA_W   = lctsa_pkg::OUT_TDATA_W;
  localparam int WINDOW_LEN    = 5;
  localparam int IDLE_PCT      = 35;
  localparam int CFG_GAP       = 4;
  localparam int SETTLE_CYCLES = 80;
  localparam int TIMEOUT_NS    = 5_000_000;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [RAW_W-1:0]       in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [SCALE_W-1:0]     cfg_data;

  int mismatch_count;
  int open_count;
  int result_count;

  // Stimulus bookkeeping.
  bit                      idle_enable;
  bit                      tare_armed;
  logic signed [RAW_W-1:0] zero_point;
  logic [SCALE_W-1:0]      current_scale;
  int                      sent_count;
  int                      tare_count;
  int                      scale_count;

  load_cell_tare_scale_average #(
    .WINDOW(WINDOW_LEN)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  tare_average_checker #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .mismatch_count(mismatch_count),
    .open_count    (open_count),
    .result_count  (result_count)
  );

  // 8 ns clock.
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Result side stalls at random while idling is enabled.
  always @(posedge clk) begin
    if (idle_enable && $urandom_range(99) < IDLE_PCT) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Sends one request, with an optional random gap in front of it. Valid is
  // only lowered for a gap, so back-to-back requests keep it high.
  task automatic send_request(input logic cmd, input logic [RAW_W-1:0] raw);
    if (idle_enable && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= raw;
    do @(posedge clk); while (!in_tready);
    sent_count++;
    if (cmd == lctsa_pkg::CMD_TARE) begin
      tare_count++;
      tare_armed = 1'b1;
    end else if (tare_armed) begin
      zero_point = raw;
      tare_armed = 1'b0;
    end
  endtask

  // Holds off new requests until every expected result has come back.
  task automatic wait_drained(input int extra);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (open_count != 0);
    repeat (extra) @(posedge clk);
  endtask

  // Writes the calibration factor; only called while the block is idle.
  task automatic write_scale(input logic [SCALE_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    current_scale = value;
    scale_count++;
  endtask

  // Raw reading: full range, near the zero point within a few grams, or an extreme.
  function automatic logic [RAW_W-1:0] pick_raw();
    int span;
    int delta;
    span  = 3 * ((current_scale == '0) ? 1 : int'(current_scale));
    delta = int'($urandom_range(2 * span)) - span;
    case ($urandom_range(9)) inside
      [0:3]: return RAW_W'($urandom);
      [4:7]: return RAW_W'(int'(zero_point) + delta);
      8: begin
        case ($urandom_range(3))
          0:       return 24'h7FFFFF;
          1:       return 24'h800000;
          2:       return 24'h000000;
          default: return 24'hFFFFFF;
        endcase
      end
      default: return zero_point;
    endcase
  endfunction

  // Mostly samples, with occasional tare requests carrying junk raw data.
  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 7) begin
        send_request(lctsa_pkg::CMD_TARE, RAW_W'($urandom));
      end else begin
        send_request(lctsa_pkg::CMD_SAMPLE, pick_raw());
      end
    end
  endtask

  // Stimulus and verdict.
  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = lctsa_pkg::CMD_SAMPLE;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    out_tready    = 1'b0;
    idle_enable   = 1'b1;
    tare_armed    = 1'b1;
    zero_point    = '0;
    current_scale = lctsa_pkg::SCALE_RESET;
    sent_count    = 0;
    tare_count    = 0;
    scale_count   = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset scale: the first sample is taken as the zero point, then near-gram
    // rounding, both extremes and enough samples to wrap the window.
    send_request(lctsa_pkg::CMD_SAMPLE, 24'h000000);
    send_request(lctsa_pkg::CMD_SAMPLE, 24'd407);
    send_request(lctsa_pkg::CMD_SAMPLE, -24'sd408);
    send_request(lctsa_pkg::CMD_SAMPLE, 24'h7FFFFF);
    send_request(lctsa_pkg::CMD_SAMPLE, 24'h800000);
    send_request(lctsa_pkg::CMD_SAMPLE, 24'h000001);
    send_request(lctsa_pkg::CMD_SAMPLE, 24'hFFFFFF);
    // A repeated tare request acts like one; its raw data is ignored.
    send_request(lctsa_pkg::CMD_TARE, 24'hFFFFFF);
    send_request(lctsa_pkg::CMD_TARE, 24'h5A5A5A);
    send_request(lctsa_pkg::CMD_SAMPLE, 24'h800000);
    send_request(lctsa_pkg::CMD_SAMPLE, 24'h7FFFFF);

    // Smallest scale: largest positive and negative weights and a full window of them.
    wait_drained(CFG_GAP);
    write_scale(16'd1);
    repeat (WINDOW_LEN) send_request(lctsa_pkg::CMD_SAMPLE, 24'h7FFFFF);
    send_request(lctsa_pkg::CMD_TARE, 24'h000000);
    send_request(lctsa_pkg::CMD_SAMPLE, 24'h7FFFFF);
    send_request(lctsa_pkg::CMD_SAMPLE, 24'h800000);
    send_request(lctsa_pkg::CMD_SAMPLE, 24'h800000);
    run_random(60);

    // Largest scale.
    wait_drained(CFG_GAP);
    write_scale(16'hFFFF);
    run_random(60);

    // A zero scale behaves like one.
    wait_drained(CFG_GAP);
    write_scale(16'd0);
    run_random(40);

    // Scale of four puts exact halves on the rounding boundary.
    wait_drained(CFG_GAP);
    write_scale(16'd4);
    send_request(lctsa_pkg::CMD_TARE, 24'h123456);
    send_request(lctsa_pkg::CMD_SAMPLE, 24'h000000);
    send_request(lctsa_pkg::CMD_SAMPLE, 24'h000001);
    send_request(lctsa_pkg::CMD_SAMPLE, 24'hFFFFFF);
    send_request(lctsa_pkg::CMD_SAMPLE, 24'h000003);
    send_request(lctsa_pkg::CMD_SAMPLE, 24'hFFFFFD);
    run_random(40);

    // Back to the reset scale with both sides running flat out.
    wait_drained(CFG_GAP);
    write_scale(lctsa_pkg::SCALE_RESET);
    idle_enable = 1'b0;
    run_random(80);
    idle_enable = 1'b1;

    // Random scales: tiny, anywhere, and near the top.
    wait_drained(CFG_GAP);
    write_scale(SCALE_W'($urandom_range(16, 1)));
    run_random(50);
    wait_drained(CFG_GAP);
    write_scale(SCALE_W'($urandom_range(65535, 1)));
    run_random(50);
    wait_drained(CFG_GAP);
    write_scale(SCALE_W'($urandom_range(65535, 1)));
    run_random(50);
    wait_drained(CFG_GAP);
    write_scale(SCALE_W'($urandom_range(65535, 60000)));
    run_random(50);

    wait_drained(SETTLE_CYCLES);
    $display("Sent %0d requests, %0d of them tare requests, under %0d scale settings",
             sent_count, tare_count, scale_count + 1);
    $display("(zero, one, full scale and rounding halves included); %0d results checked.",
             result_count);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(TIMEOUT_NS);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/lctsa_pkg.sv
rtl/core/lctsa_div.sv
rtl/core/lctsa_window.sv
rtl/core/load_cell_tare_scale_average.sv
tb/sv/tare_average_checker.sv
tb/sv/testbench.sv
